/* design/group_serialized_job_queue_unit_assert.svh */
// assertion helpers for the job queue
`ifndef GROUP_SERIALIZED_JOB_QUEUE_UNIT_ASSERT_SVH
`define GROUP_SERIALIZED_JOB_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define GSJQ_AST_NOW(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define GSJQ_AST_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* design/gsjq_pkg.sv */
package gsjq_pkg;

    localparam int JOB_W    = 16;
    localparam int TMO_W    = 16;
    localparam int GRP_W    = 8;
    localparam int CAP_W    = 5;
    localparam int CMD_W    = 2;
    localparam int STS_W    = 3;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_FIN
    } t_state;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DISP = 2'd1,
        CMD_CMPL = 2'd2
    } t_cmd;

    typedef enum logic [STS_W-1:0] {
        STS_ACCEPTED   = 3'd0,
        STS_FULL       = 3'd1,
        STS_DISPATCHED = 3'd2,
        STS_FORCED     = 3'd3,
        STS_NONE       = 3'd4,
        STS_COMPLETED  = 3'd5
    } t_status;

    typedef struct packed {
        t_status          status;
        logic [JOB_W-1:0] job_id;
        logic [TMO_W-1:0] timeout;
        logic [GRP_W-1:0] group_id;
        logic             has_group;
    } t_res;

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_ctl;

endpackage

/* design/gsjq_cmd_if.sv */
interface gsjq_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [gsjq_pkg::CMD_W-1:0]  command;
    logic [gsjq_pkg::JOB_W-1:0]  job_id;
    logic [gsjq_pkg::TMO_W-1:0]  timeout_secs;
    logic [gsjq_pkg::GRP_W-1:0]  group_id;
    logic                        has_group;

    modport source (
        output valid, command, job_id, timeout_secs, group_id, has_group,
        input  ready
    );
    modport sink (
        input  valid, command, job_id, timeout_secs, group_id, has_group,
        output ready
    );
endinterface

/* design/gsjq_res_if.sv */
interface gsjq_res_if;
    logic                        valid;
    logic                        ready;
    logic [gsjq_pkg::STS_W-1:0]  status;
    logic [gsjq_pkg::JOB_W-1:0]  out_job_id;
    logic [gsjq_pkg::TMO_W-1:0]  out_timeout;
    logic [gsjq_pkg::GRP_W-1:0]  out_group_id;
    logic                        out_has_group;

    modport source (
        output valid, status, out_job_id, out_timeout, out_group_id, out_has_group,
        input  ready
    );
    modport sink (
        input  valid, status, out_job_id, out_timeout, out_group_id, out_has_group,
        output ready
    );
endinterface

/* design/gsjq_cfg_if.sv */
interface gsjq_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [gsjq_pkg::CAP_W-1:0]  queue_capacity;

    modport source (
        output valid, queue_capacity,
        input  ready
    );
    modport sink (
        input  valid, queue_capacity,
        output ready
    );
endinterface

/* design/gsjq_slot_store.sv */
module gsjq_slot_store #(
    parameter int DATA_W = 42,
    parameter int ADDR_W = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  gsjq_pkg::t_mem_ctl   i_ctl,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [DATA_W-1:0]    i_wr_data,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output logic [DATA_W-1:0]    o_rd_data,
    output logic                 o_rd_valid,
    output logic [ADDR_W-1:0]    o_rd_tag
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rd_data;
    logic [ADDR_W-1:0] r_rd_tag;
    logic              r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[i_rd_addr];
            r_rd_tag  <= i_rd_addr;
        end
    end

    // tag travels with the data so the caller knows which slot came back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_ctl.rd;
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_valid = r_rd_valid;
    assign o_rd_tag   = r_rd_tag;

endmodule

/* design/group_serialized_job_queue_unit.sv */
// channel   dir  beat                              payload
// i_cmd     in   one command                       command, job_id, timeout_secs,
//                                                  group_id, has_group
// o_res     out  one result per command            status, out_job_id, out_timeout,
//                                                  out_group_id, out_has_group
// i_cfg     in   capacity write                    queue_capacity
//
// one command at a time; the slot memory's single read port sets the pace
// enqueue: a grouped job reads the queued entries until one of its group matches; ungrouped reads none
// dispatch: reads entries until the first unblocked one (else the head), then moves up those behind it
// complete: a grouped complete reads entries until the group's oldest match
// sync reset clears counts and control; slot memory is not cleared, only
// entries below the queued count are ever read; a stalled o_res holds the unit
module group_serialized_job_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_WORKERS = 16,
    parameter int GROUP_BITS  = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    gsjq_cmd_if.sink     i_cmd,
    gsjq_res_if.source   o_res,
    gsjq_cfg_if.sink     i_cfg
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int RW = $clog2(MAX_WORKERS + 1);
    localparam int GW = (GROUP_BITS < gsjq_pkg::GRP_W) ? GROUP_BITS : gsjq_pkg::GRP_W;
    localparam int LW = (CW > gsjq_pkg::CAP_W) ? CW : gsjq_pkg::CAP_W;
    localparam int SW = gsjq_pkg::JOB_W + gsjq_pkg::TMO_W + GW + 2;

    typedef struct packed {
        logic [gsjq_pkg::JOB_W-1:0] job;
        logic [gsjq_pkg::TMO_W-1:0] tmo;
        logic [GW-1:0]              grp;
        logic                       grouped;
        logic                       blocked;
    } t_slot;

    gsjq_pkg::t_state  r_state, n_state;
    gsjq_pkg::t_cmd    r_cmd, n_cmd;
    gsjq_pkg::t_status r_status, n_status;
    logic [gsjq_pkg::JOB_W-1:0] r_job, n_job;
    logic [gsjq_pkg::TMO_W-1:0] r_tmo, n_tmo;
    logic [GW-1:0]     r_grp, n_grp;
    logic              r_grouped, n_grouped;
    logic [CW-1:0]     r_count, n_count;
    logic [RW-1:0]     r_run, n_run;
    logic [gsjq_pkg::CAP_W-1:0] r_cap;
    logic [CW-1:0]     r_issue, n_issue;
    t_slot             r_pick, n_pick;
    t_slot             r_head, n_head;
    gsjq_pkg::t_res    r_out, n_out;
    logic              r_out_valid, n_out_valid;

    gsjq_pkg::t_mem_ctl w_ctl;
    logic [AW-1:0]     w_wr_addr;
    t_slot             w_wr_data;
    logic [SW-1:0]     w_rd_raw;
    t_slot             w_rd;
    logic              w_rd_valid;
    logic [AW-1:0]     w_rd_tag;
    logic              w_full;
    logic              w_issue_ok;
    logic              w_match;
    logic              w_disp;
    logic [RW-1:0]     w_run_inc;

    gsjq_slot_store #(
        .DATA_W (SW),
        .ADDR_W (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_wr_addr  (w_wr_addr),
        .i_wr_data  (w_wr_data),
        .i_rd_addr  (r_issue[AW-1:0]),
        .o_rd_data  (w_rd_raw),
        .o_rd_valid (w_rd_valid),
        .o_rd_tag   (w_rd_tag)
    );

    assign w_rd       = t_slot'(w_rd_raw);
    assign w_full     = (r_count >= CW'(QUEUE_DEPTH)) || (LW'(r_count) >= LW'(r_cap));
    assign w_issue_ok = (r_issue < r_count);
    assign w_match    = w_rd.grouped && (w_rd.grp == r_grp);
    assign w_disp     = (r_status == gsjq_pkg::STS_DISPATCHED) ||
                        (r_status == gsjq_pkg::STS_FORCED);
    assign w_run_inc  = (r_run < RW'(MAX_WORKERS)) ? r_run + 1'b1 : r_run;

    assign i_cmd.ready = (r_state == gsjq_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    // reads run ahead of writes: a read never targets the slot written in the
    // same cycle, so no forwarding path is needed
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_job       = r_job;
        n_tmo       = r_tmo;
        n_grp       = r_grp;
        n_grouped   = r_grouped;
        n_count     = r_count;
        n_run       = r_run;
        n_issue     = r_issue;
        n_pick      = r_pick;
        n_head      = r_head;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        w_ctl       = '0;
        w_wr_addr   = r_count[AW-1:0];
        w_wr_data   = '{job: r_job, tmo: r_tmo, grp: r_grp, grouped: r_grouped,
                        blocked: 1'b0};

        case (r_state)
            gsjq_pkg::ST_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd     = gsjq_pkg::t_cmd'(i_cmd.command);
                    n_job     = i_cmd.job_id;
                    n_tmo     = i_cmd.timeout_secs;
                    n_grp     = i_cmd.group_id[GW-1:0];
                    n_grouped = i_cmd.has_group;
                    n_issue   = '0;
                    case (gsjq_pkg::t_cmd'(i_cmd.command))
                        gsjq_pkg::CMD_ENQ: begin
                            if (w_full) begin
                                n_status = gsjq_pkg::STS_FULL;
                                n_state  = gsjq_pkg::ST_FIN;
                            end else begin
                                if (!i_cmd.has_group) begin
                                    n_issue = r_count;
                                end
                                n_state = gsjq_pkg::ST_SCAN;
                            end
                        end
                        gsjq_pkg::CMD_DISP: begin
                            n_state = gsjq_pkg::ST_SCAN;
                        end
                        gsjq_pkg::CMD_CMPL: begin
                            if (r_run != '0) begin
                                n_run = r_run - 1'b1;
                            end
                            if (!i_cmd.has_group) begin
                                n_issue = r_count;
                            end
                            n_state = gsjq_pkg::ST_SCAN;
                        end
                        default: begin
                            n_status = gsjq_pkg::STS_NONE;
                            n_state  = gsjq_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            gsjq_pkg::ST_SCAN: begin
                // keep streaming reads; a dispatch hit turns them into the shift
                if (w_issue_ok) begin
                    w_ctl.rd = 1'b1;
                    n_issue  = r_issue + 1'b1;
                end
                if (w_rd_valid) begin
                    case (r_cmd)
                        gsjq_pkg::CMD_ENQ: begin
                            if (w_match) begin
                                w_ctl.wr          = 1'b1;
                                w_wr_data.blocked = 1'b1;
                                n_count           = r_count + 1'b1;
                                n_status          = gsjq_pkg::STS_ACCEPTED;
                                n_state           = gsjq_pkg::ST_FIN;
                            end
                        end
                        gsjq_pkg::CMD_DISP: begin
                            if (w_rd_tag == '0) begin
                                n_head = w_rd;
                            end
                            if (!w_rd.blocked) begin
                                n_pick   = w_rd;
                                n_status = gsjq_pkg::STS_DISPATCHED;
                                n_state  = gsjq_pkg::ST_SHIFT;
                            end
                        end
                        gsjq_pkg::CMD_CMPL: begin
                            if (w_match) begin
                                w_ctl.wr          = 1'b1;
                                w_wr_addr         = w_rd_tag;
                                w_wr_data         = w_rd;
                                w_wr_data.blocked = 1'b0;
                                n_status          = gsjq_pkg::STS_COMPLETED;
                                n_state           = gsjq_pkg::ST_FIN;
                            end
                        end
                        default: begin
                            n_state = gsjq_pkg::ST_FIN;
                        end
                    endcase
                end else if (!w_issue_ok) begin
                    // every entry seen, no hit
                    case (r_cmd)
                        gsjq_pkg::CMD_ENQ: begin
                            w_ctl.wr = 1'b1;
                            n_count  = r_count + 1'b1;
                            n_status = gsjq_pkg::STS_ACCEPTED;
                            n_state  = gsjq_pkg::ST_FIN;
                        end
                        gsjq_pkg::CMD_DISP: begin
                            if (r_count != '0 && r_run == '0) begin
                                n_pick   = r_head;
                                n_status = gsjq_pkg::STS_FORCED;
                                n_issue  = CW'(1);
                                n_state  = gsjq_pkg::ST_SHIFT;
                            end else begin
                                n_status = gsjq_pkg::STS_NONE;
                                n_state  = gsjq_pkg::ST_FIN;
                            end
                        end
                        gsjq_pkg::CMD_CMPL: begin
                            n_status = gsjq_pkg::STS_COMPLETED;
                            n_state  = gsjq_pkg::ST_FIN;
                        end
                        default: begin
                            n_status = gsjq_pkg::STS_NONE;
                            n_state  = gsjq_pkg::ST_FIN;
                        end
                    endcase
                end
            end

            gsjq_pkg::ST_SHIFT: begin
                // slot j comes back and moves down to j-1
                if (w_issue_ok) begin
                    w_ctl.rd = 1'b1;
                    n_issue  = r_issue + 1'b1;
                end
                if (w_rd_valid) begin
                    w_ctl.wr  = 1'b1;
                    w_wr_addr = w_rd_tag - 1'b1;
                    w_wr_data = w_rd;
                end else if (!w_issue_ok) begin
                    n_count = r_count - 1'b1;
                    n_run   = w_run_inc;
                    n_state = gsjq_pkg::ST_FIN;
                end
            end

            gsjq_pkg::ST_FIN: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out.status    = r_status;
                    n_out.job_id    = w_disp ? r_pick.job : '0;
                    n_out.timeout   = w_disp ? r_pick.tmo : '0;
                    n_out.group_id  = w_disp ? gsjq_pkg::GRP_W'(r_pick.grp) : '0;
                    n_out.has_group = w_disp && r_pick.grouped;
                    n_out_valid     = 1'b1;
                    n_state         = gsjq_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = gsjq_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gsjq_pkg::ST_IDLE;
            r_count     <= '0;
            r_run       <= '0;
            r_cap       <= gsjq_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_cap <= i_cfg.queue_capacity;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_status  <= n_status;
        r_job     <= n_job;
        r_tmo     <= n_tmo;
        r_grp     <= n_grp;
        r_grouped <= n_grouped;
        r_issue   <= n_issue;
        r_pick    <= n_pick;
        r_head    <= n_head;
        r_out     <= n_out;
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.status        = r_out.status;
    assign o_res.out_job_id    = r_out.job_id;
    assign o_res.out_timeout   = r_out.timeout;
    assign o_res.out_group_id  = r_out.group_id;
    assign o_res.out_has_group = r_out.has_group;

`include "group_serialized_job_queue_unit_assert.svh"

    `GSJQ_AST_NEXT(a_full_reject,
        i_cmd.valid && i_cmd.ready && (i_cmd.command == gsjq_pkg::CMD_ENQ) && w_full,
        (r_state == gsjq_pkg::ST_FIN) && (r_status == gsjq_pkg::STS_FULL) && $stable(r_count),
        "enqueue into a full queue was not rejected")
    `GSJQ_AST_NOW(a_write_in_range,
        w_ctl.wr,
        (CW'(w_wr_addr) <= r_count) && (r_count <= CW'(QUEUE_DEPTH)),
        "slot write beyond the queued entries")
    `GSJQ_AST_NEXT(a_take_one,
        (r_state == gsjq_pkg::ST_SHIFT) && (n_state == gsjq_pkg::ST_FIN),
        (r_count == $past(r_count) - 1'b1) && w_disp,
        "dispatch did not remove exactly one entry")

endmodule

/* bench/tb_group_serialized_job_queue_unit.sv */
module tb_group_serialized_job_queue_unit;
    import gsjq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int WORKERS     = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 48;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam t_res WANT_NONE = '{STS_NONE, 16'h0, 16'h0, 8'h0, 1'b0};
    localparam t_res WANT_DONE = '{STS_COMPLETED, 16'h0, 16'h0, 8'h0, 1'b0};
    localparam t_res WANT_OK   = '{STS_ACCEPTED, 16'h0, 16'h0, 8'h0, 1'b0};
    localparam t_res WANT_FULL = '{STS_FULL, 16'h0, 16'h0, 8'h0, 1'b0};
    localparam t_res FROM_MODEL = '0;

    typedef struct packed {
        bit               is_cfg;
        logic [CAP_W-1:0] cap;
        logic [CMD_W-1:0] cmd;
        logic [JOB_W-1:0] job;
        logic [TMO_W-1:0] tmo;
        logic [GRP_W-1:0] grp;
        logic             has;
        bit               typed;
        t_res             want;
    } plan_row_t;

    // directed opening: corner values, blocking, forced path, capacity corners
    localparam plan_row_t PLAN [0:26] = '{
        '{1'b0, 5'd0, CMD_DISP, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, WANT_NONE},
        '{1'b0, 5'd0, CMD_CMPL, 16'h0000, 16'h0000, 8'h00, 1'b1, 1'b1, WANT_DONE},
        '{1'b0, 5'd0, CMD_UNUSED, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, WANT_NONE},
        '{1'b0, 5'd0, CMD_ENQ, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1, WANT_OK},
        '{1'b0, 5'd0, CMD_ENQ, 16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b1, WANT_OK},
        '{1'b0, 5'd0, CMD_ENQ, 16'h1234, 16'h5678, 8'hFF, 1'b0, 1'b1, WANT_OK},
        '{1'b0, 5'd0, CMD_DISP, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1,
          '{STS_DISPATCHED, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b1}},
        '{1'b0, 5'd0, CMD_DISP, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_DISP, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1, WANT_NONE},
        '{1'b0, 5'd0, CMD_CMPL, 16'h0000, 16'h0000, 8'hFF, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_DISP, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_CMPL, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_DISP, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b1,
          '{STS_FORCED, 16'h0000, 16'h0000, 8'hFF, 1'b1}},
        '{1'b0, 5'd0, CMD_CMPL, 16'h0000, 16'h0000, 8'hFF, 1'b1, 1'b0, FROM_MODEL},
        '{1'b1, 5'd0, CMD_ENQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_ENQ, 16'h00FF, 16'hFF00, 8'h01, 1'b1, 1'b1, WANT_FULL},
        '{1'b1, 5'd2, CMD_ENQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_ENQ, 16'hAAAA, 16'h5555, 8'hAA, 1'b1, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_ENQ, 16'h5555, 16'hAAAA, 8'h55, 1'b1, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_ENQ, 16'h0F0F, 16'hF0F0, 8'h0F, 1'b0, 1'b1, WANT_FULL},
        '{1'b1, 5'd1, CMD_ENQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_ENQ, 16'h0001, 16'h0001, 8'h01, 1'b0, 1'b1, WANT_FULL},
        '{1'b0, 5'd0, CMD_DISP, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_DISP, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_ENQ, 16'h7FFF, 16'h8000, 8'h80, 1'b1, 1'b0, FROM_MODEL},
        '{1'b1, 5'd31, CMD_ENQ, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, FROM_MODEL},
        '{1'b0, 5'd0, CMD_DISP, 16'h0000, 16'h0000, 8'h00, 1'b0, 1'b0, FROM_MODEL}
    };

    localparam logic [CAP_W-1:0] SEG_CAP [0:5] = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd5, 5'd12};
    localparam int SEG_LEN [0:5] = '{330, 330, 330, 60, 400, 400};

    logic i_clk;
    logic i_rst_n;

    gsjq_cmd_if cmd_ch ();
    gsjq_res_if res_ch ();
    gsjq_cfg_if cfg_ch ();

    group_serialized_job_queue_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch),
        .i_cfg   (cfg_ch)
    );

    // shadow of the queue contents, oldest entry at index 0
    logic [JOB_W-1:0] ent_job     [DEPTH];
    logic [TMO_W-1:0] ent_tmo     [DEPTH];
    logic [GRP_W-1:0] ent_grp     [DEPTH];
    bit               ent_grouped [DEPTH];
    bit               ent_held    [DEPTH];
    int               depth_used   = 0;
    int               busy_workers = 0;
    logic [CAP_W-1:0] cap_setting  = CAP_RESET;

    logic [GRP_W-1:0] running_groups [$];
    t_res             awaited_replies [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_cycles  = 0;
    int mismatches    = 0;
    int jobs_sent     = 0;
    int replies_seen  = 0;
    int cap_writes    = 0;
    int status_tally [8];

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_res predict_reply(input logic [CMD_W-1:0] cmd,
                                           input logic [JOB_W-1:0] job,
                                           input logic [TMO_W-1:0] tmo,
                                           input logic [GRP_W-1:0] grp,
                                           input logic has);
        t_res r;
        int   lim;
        int   pick;
        bit   held;
        r = '0;
        r.status = STS_NONE;
        lim = (cap_setting > DEPTH) ? DEPTH : int'(cap_setting);
        case (cmd)
            CMD_ENQ: begin
                if (depth_used >= lim) begin
                    r.status = STS_FULL;
                end else begin
                    held = 1'b0;
                    for (int i = 0; i < depth_used; i++)
                        if (has && ent_grouped[i] && ent_grp[i] == grp)
                            held = 1'b1;
                    ent_job[depth_used]     = job;
                    ent_tmo[depth_used]     = tmo;
                    ent_grp[depth_used]     = grp;
                    ent_grouped[depth_used] = has;
                    ent_held[depth_used]    = held;
                    depth_used++;
                    r.status = STS_ACCEPTED;
                end
            end
            CMD_DISP: begin
                pick = -1;
                for (int i = depth_used - 1; i >= 0; i--)
                    if (!ent_held[i])
                        pick = i;
                if (pick >= 0) begin
                    r.status = STS_DISPATCHED;
                end else if (depth_used > 0 && busy_workers == 0) begin
                    // every entry blocked and nobody running: take the head anyway
                    pick = 0;
                    r.status = STS_FORCED;
                end
                if (pick >= 0) begin
                    r.job_id    = ent_job[pick];
                    r.timeout   = ent_tmo[pick];
                    r.group_id  = ent_grp[pick];
                    r.has_group = ent_grouped[pick];
                    for (int i = pick; i + 1 < depth_used; i++) begin
                        ent_job[i]     = ent_job[i+1];
                        ent_tmo[i]     = ent_tmo[i+1];
                        ent_grp[i]     = ent_grp[i+1];
                        ent_grouped[i] = ent_grouped[i+1];
                        ent_held[i]    = ent_held[i+1];
                    end
                    depth_used--;
                    if (busy_workers < WORKERS)
                        busy_workers++;
                    if (r.has_group)
                        running_groups.push_back(r.group_id);
                end
            end
            CMD_CMPL: begin
                if (busy_workers > 0)
                    busy_workers--;
                if (has) begin
                    pick = -1;
                    for (int i = depth_used - 1; i >= 0; i--)
                        if (ent_grouped[i] && ent_grp[i] == grp)
                            pick = i;
                    if (pick >= 0)
                        ent_held[pick] = 1'b0;
                end
                r.status = STS_COMPLETED;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task automatic check_reply();
        t_res want;
        if (awaited_replies.size() == 0) begin
            note_mismatch($sformatf("result beat with nothing pending, status %0d",
                                    res_ch.status));
        end else begin
            want = awaited_replies.pop_front();
            replies_seen++;
            if (res_ch.status !== want.status)
                note_mismatch($sformatf("status %0d, want %0d", res_ch.status, want.status));
            if (res_ch.out_job_id !== want.job_id)
                note_mismatch($sformatf("job id %h, want %h", res_ch.out_job_id, want.job_id));
            if (res_ch.out_timeout !== want.timeout)
                note_mismatch($sformatf("timeout %h, want %h",
                                        res_ch.out_timeout, want.timeout));
            if (res_ch.out_group_id !== want.group_id)
                note_mismatch($sformatf("group %h, want %h",
                                        res_ch.out_group_id, want.group_id));
            if (res_ch.out_has_group !== want.has_group)
                note_mismatch($sformatf("has_group %b, want %b",
                                        res_ch.out_has_group, want.has_group));
        end
    endtask

    // result side: check at the edge, then pick ready for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
            check_reply();
        if ((cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) ||
            (cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
            stall_cycles = 0;
        else
            stall_cycles = stall_cycles + 1;
        res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("watchdog: no beat on any channel for %0d cycles", STALL_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_job(input logic [CMD_W-1:0] cmd, input logic [JOB_W-1:0] job,
                            input logic [TMO_W-1:0] tmo, input logic [GRP_W-1:0] grp,
                            input logic has, input bit typed, input t_res want);
        t_res model;
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= cmd;
        cmd_ch.job_id       <= job;
        cmd_ch.timeout_secs <= tmo;
        cmd_ch.group_id     <= grp;
        cmd_ch.has_group    <= has;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        model = predict_reply(cmd, job, tmo, grp, has);
        awaited_replies.push_back(typed ? want : model);
        status_tally[model.status]++;
        jobs_sent++;
    endtask

    task automatic drain_replies();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (awaited_replies.size() != 0);
    endtask

    // capacity changes only with the unit idle
    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain_replies();
        cfg_ch.valid          <= 1'b1;
        cfg_ch.queue_capacity <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        cap_setting = value;
        cap_writes++;
    endtask

    initial begin
        int               roll;
        int               pick;
        int               w_enq;
        int               w_disp;
        int               w_cmpl;
        logic [CMD_W-1:0] cmd;
        logic [JOB_W-1:0] job;
        logic [TMO_W-1:0] tmo;
        logic [GRP_W-1:0] grp;
        logic             has;

        i_rst_n               = 1'b0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.command        = CMD_ENQ;
        cmd_ch.job_id         = '0;
        cmd_ch.timeout_secs   = '0;
        cmd_ch.group_id       = '0;
        cmd_ch.has_group      = 1'b0;
        res_ch.ready          = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.queue_capacity = CAP_RESET;
        foreach (status_tally[k])
            status_tally[k] = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 10;
        recv_idle_pct = 55;
        foreach (PLAN[k]) begin
            if (PLAN[k].is_cfg)
                write_capacity(PLAN[k].cap);
            else
                send_job(PLAN[k].cmd, PLAN[k].job, PLAN[k].tmo, PLAN[k].grp,
                         PLAN[k].has, PLAN[k].typed, PLAN[k].want);
        end

        for (int seg = 0; seg < 6; seg++) begin
            send_idle_pct = (seg < 2) ? 10 : (seg < 4) ? 55 : 0;
            recv_idle_pct = (seg < 2) ? 55 : (seg < 4) ? 10 : 0;
            // odd segments lean on completes so the running count falls to zero
            w_enq  = (seg % 2 == 0) ? 45 : 40;
            w_disp = (seg % 2 == 0) ? 30 : 25;
            w_cmpl = (seg % 2 == 0) ? 20 : 30;
            write_capacity(SEG_CAP[seg]);
            for (int n = 0; n < SEG_LEN[seg]; n++) begin
                roll = $urandom_range(99);
                cmd  = (roll < w_enq) ? CMD_ENQ :
                       (roll < w_enq + w_disp) ? CMD_DISP :
                       (roll < w_enq + w_disp + w_cmpl) ? CMD_CMPL : CMD_UNUSED;
                job  = $urandom;
                tmo  = $urandom;
                // a few hot groups so that blocking actually happens
                grp  = ($urandom_range(99) < 75) ? GRP_W'($urandom_range(3))
                                                 : GRP_W'($urandom_range(255));
                has  = ($urandom_range(99) < 70);
                if (cmd == CMD_CMPL && running_groups.size() != 0 &&
                    $urandom_range(99) < 80) begin
                    pick = $urandom_range(running_groups.size() - 1);
                    grp  = running_groups[pick];
                    has  = 1'b1;
                    running_groups.delete(pick);
                end
                send_job(cmd, job, tmo, grp, has, 1'b0, FROM_MODEL);
            end
        end

        drain_replies();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (awaited_replies.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", awaited_replies.size()));

        $display("covered %0d commands and %0d capacity writes, %0d results compared",
                 jobs_sent, cap_writes, replies_seen);
        $display("mix: %0d queued, %0d refused full, %0d dispatched, %0d forced, %0d idle, %0d done",
                 status_tally[STS_ACCEPTED], status_tally[STS_FULL],
                 status_tally[STS_DISPATCHED], status_tally[STS_FORCED],
                 status_tally[STS_NONE], status_tally[STS_COMPLETED]);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
